/* hdl/pfe_pkg.sv */
`default_nettype none

package pfe_pkg;

   localparam int SIDE       = 5;
   localparam int CELL_W     = 5;
   localparam int POS_W      = 3;
   localparam int BANK_CELLS = 12;
   localparam int BANK_W     = BANK_CELLS * CELL_W;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_LOW  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_MID  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LAST = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FILLER   = 8'd3;

   localparam logic [CELL_W-1:0] LETTER_I     = 5'd8;
   localparam logic [CELL_W-1:0] LETTER_J     = 5'd9;
   localparam logic [CELL_W-1:0] LETTER_X     = 5'd23;
   localparam logic [CELL_W-1:0] LETTER_Z     = 5'd25;

   typedef logic [SIDE-1:0][SIDE-1:0][CELL_W-1:0] square_type;

   typedef struct packed {
      square_type        cells;
      logic [CELL_W-1:0] filler;
   } cfg_type;

   typedef struct packed {
      logic [CELL_W-1:0] letter;
      logic              end_of_text;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0] cipher_first;
      logic [CELL_W-1:0] cipher_second;
      logic              not_found;
      logic              last;
   } rsp_type;

   function automatic logic [CELL_W-1:0] fold_letter(input logic [CELL_W-1:0] v);
      fold_letter = (v == LETTER_J) ? LETTER_I : v;
   endfunction

endpackage

`default_nettype wire

/* hdl/pfe_csr.sv */
`default_nettype none

module pfe_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [pfe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pfe_pkg::CSR_DATA_W-1:0]    csr_data,
   output pfe_pkg::cfg_type                       cfg
);

   logic [pfe_pkg::BANK_W-1:0] key_low_ff, key_low_in;
   logic [pfe_pkg::BANK_W-1:0] key_mid_ff, key_mid_in;
   logic [pfe_pkg::CELL_W-1:0] key_last_ff, key_last_in;
   logic [pfe_pkg::CELL_W-1:0] filler_ff, filler_in;
   logic                       wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid;

   always_comb begin
      key_low_in  = key_low_ff;
      key_mid_in  = key_mid_ff;
      key_last_in = key_last_ff;
      filler_in   = filler_ff;
      if (wr) begin
         case (csr_index)
            pfe_pkg::REG_KEY_LOW:  key_low_in  = csr_data[pfe_pkg::BANK_W-1:0];
            pfe_pkg::REG_KEY_MID:  key_mid_in  = csr_data[pfe_pkg::BANK_W-1:0];
            pfe_pkg::REG_KEY_LAST: key_last_in = csr_data[pfe_pkg::CELL_W-1:0];
            pfe_pkg::REG_FILLER:   filler_in   = csr_data[pfe_pkg::CELL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_mid_ff  <= '0;
         key_last_ff <= pfe_pkg::LETTER_Z;
         filler_ff   <= pfe_pkg::LETTER_X;
      end else begin
         key_low_ff  <= key_low_in;
         key_mid_ff  <= key_mid_in;
         key_last_ff <= key_last_in;
         filler_ff   <= filler_in;
      end
   end

   always_comb begin
      int idx;
      idx = 0;
      for (int r = 0; r < pfe_pkg::SIDE; r++) begin
         for (int c = 0; c < pfe_pkg::SIDE; c++) begin
            idx = r * pfe_pkg::SIDE + c;
            if (idx < pfe_pkg::BANK_CELLS) begin
               cfg.cells[r][c] = key_low_ff[pfe_pkg::CELL_W*idx +: pfe_pkg::CELL_W];
            end else if (idx < 2 * pfe_pkg::BANK_CELLS) begin
               cfg.cells[r][c] =
                  key_mid_ff[pfe_pkg::CELL_W*(idx-pfe_pkg::BANK_CELLS) +: pfe_pkg::CELL_W];
            end else begin
               cfg.cells[r][c] = key_last_ff;
            end
         end
      end
      cfg.filler = filler_ff;
   end

endmodule

`default_nettype wire

/* hdl/pfe_lookup.sv */
`default_nettype none

module pfe_lookup (
   input  wire pfe_pkg::square_type          cells,
   input  wire logic [pfe_pkg::CELL_W-1:0]   first_in,
   input  wire logic [pfe_pkg::CELL_W-1:0]   second_in,
   output logic [pfe_pkg::CELL_W-1:0]        cipher_first,
   output logic [pfe_pkg::CELL_W-1:0]        cipher_second,
   output logic                              not_found
);

   logic                      hit_a, hit_b;
   logic [pfe_pkg::POS_W-1:0] row_a, col_a, row_b, col_b;
   logic [pfe_pkg::POS_W-1:0] row_a_o, col_a_o, row_b_o, col_b_o;

   function automatic logic [pfe_pkg::POS_W-1:0] wrap_inc(input logic [pfe_pkg::POS_W-1:0] v);
      wrap_inc = (v == pfe_pkg::POS_W'(pfe_pkg::SIDE - 1)) ? '0 : v + 1'b1;
   endfunction

   // highest-numbered matching cell wins
   always_comb begin
      hit_a = 1'b0;
      hit_b = 1'b0;
      row_a = '0;
      col_a = '0;
      row_b = '0;
      col_b = '0;
      for (int r = 0; r < pfe_pkg::SIDE; r++) begin
         for (int c = 0; c < pfe_pkg::SIDE; c++) begin
            if (cells[r][c] == first_in) begin
               hit_a = 1'b1;
               row_a = pfe_pkg::POS_W'(r);
               col_a = pfe_pkg::POS_W'(c);
            end
            if (cells[r][c] == second_in) begin
               hit_b = 1'b1;
               row_b = pfe_pkg::POS_W'(r);
               col_b = pfe_pkg::POS_W'(c);
            end
         end
      end
   end

   always_comb begin
      row_a_o = row_a;
      row_b_o = row_b;
      col_a_o = col_b;
      col_b_o = col_a;
      if (row_a == row_b) begin
         col_a_o = wrap_inc(col_a);
         col_b_o = wrap_inc(col_b);
      end else if (col_a == col_b) begin
         row_a_o = wrap_inc(row_a);
         row_b_o = wrap_inc(row_b);
         col_a_o = col_a;
         col_b_o = col_b;
      end
   end

   always_comb begin
      not_found = !(hit_a && hit_b);
      if (not_found) begin
         cipher_first  = '0;
         cipher_second = '0;
      end else begin
         cipher_first  = cells[row_a_o][col_a_o];
         cipher_second = cells[row_b_o][col_b_o];
      end
   end

endmodule

`default_nettype wire

/* hdl/playfair_digraph_encrypt_core.sv */
`default_nettype none

// Path: an emitted digraph reaches rsp through the input register and then the result register.
// Throughput: one item per cycle unless req_stall; a doubled letter at end of text
// yields two digraphs; an emitting item waits while the second leaves the result register.
// req_stall follows rsp_stall through the result register's free slot.
// Reset: synchronous; clears pending letter, both registers' valids, key cells 0..23 to 0,
// cell 24 to Z and filler to X. No clearing pass.

module playfair_digraph_encrypt_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire pfe_pkg::req_type                  req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output pfe_pkg::rsp_type                       rsp_payload,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [pfe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pfe_pkg::CSR_DATA_W-1:0]    csr_data
);

   pfe_pkg::cfg_type           cfg;

   logic                       in_valid_ff, in_valid_in;
   pfe_pkg::req_type           in_item_ff;
   logic                       pend_valid_ff, pend_valid_in;
   logic [pfe_pkg::CELL_W-1:0] pend_letter_ff, pend_letter_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       dup_ff, dup_in;
   pfe_pkg::rsp_type           rsp_ff, rsp_in;

   logic [pfe_pkg::CELL_W-1:0] letter, filler, pair_a, pair_b;
   logic                       same, emit, dup, out_free, move, accept;
   logic [pfe_pkg::CELL_W-1:0] ciph_a, ciph_b;
   logic                       miss;

   pfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign letter = pfe_pkg::fold_letter(in_item_ff.letter);
   assign filler = pfe_pkg::fold_letter(cfg.filler);
   assign same   = pend_valid_ff && (pend_letter_ff == letter);
   assign emit   = pend_valid_ff || in_item_ff.end_of_text;
   assign dup    = same && in_item_ff.end_of_text;
   assign pair_a = pend_valid_ff ? pend_letter_ff : letter;
   assign pair_b = (pend_valid_ff && !same) ? letter : filler;

   pfe_lookup u_lookup (
      .cells         (cfg.cells),
      .first_in      (pair_a),
      .second_in     (pair_b),
      .cipher_first  (ciph_a),
      .cipher_second (ciph_b),
      .not_found     (miss)
   );

   assign out_free  = !rsp_valid_ff || (!rsp_stall && !dup_ff);
   assign move      = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !move;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in = accept || (in_valid_ff && !move);

   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_letter_in = pend_letter_ff;
      if (move) begin
         if (!pend_valid_ff) begin
            pend_valid_in  = !in_item_ff.end_of_text;
            pend_letter_in = in_item_ff.end_of_text ? '0 : letter;
         end else if (!same || in_item_ff.end_of_text) begin
            pend_valid_in  = 1'b0;
            pend_letter_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      dup_in       = dup_ff;
      rsp_in       = rsp_ff;
      if (move && emit) begin
         rsp_valid_in         = 1'b1;
         dup_in               = dup;
         rsp_in.cipher_first  = ciph_a;
         rsp_in.cipher_second = ciph_b;
         rsp_in.not_found     = miss;
         rsp_in.last          = !dup;
      end else if (rsp_valid_ff && !rsp_stall) begin
         if (dup_ff) begin
            dup_in      = 1'b0;
            rsp_in.last = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         pend_valid_ff  <= 1'b0;
         pend_letter_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         dup_ff         <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         pend_valid_ff  <= pend_valid_in;
         pend_letter_ff <= pend_letter_in;
         rsp_valid_ff   <= rsp_valid_in;
         dup_ff         <= dup_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
